@@ hdl/u8cw_pkg.sv @@
package u8cw_pkg;

    // code point and column width types
    typedef logic [20:0] cp_t;
    typedef logic [1:0]  colw_t;

    // fixed code point values
    localparam cp_t REPL_CP = 21'h00FFFD;
    localparam cp_t CP_MAX  = 21'h10FFFF;
    localparam cp_t SURR_LO = 21'h00D800;
    localparam cp_t SURR_HI = 21'h00DFFF;

    // smallest code point that each sequence length may carry
    localparam cp_t MIN_CP2 = 21'h000080;
    localparam cp_t MIN_CP3 = 21'h000800;
    localparam cp_t MIN_CP4 = 21'h010000;

    // byte classes
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_CODE = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD_BAD  = 8'hF8;

    // sequence lengths held in the pending length register
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // column widths
    localparam colw_t COLW_ZERO   = 2'd0;
    localparam colw_t COLW_NARROW = 2'd1;
    localparam colw_t COLW_WIDE   = 2'd2;

    // width range table entry
    typedef struct packed {
        cp_t   lo;
        cp_t   hi;
        colw_t w;
    } span_t;

    localparam int NUM_SPANS = 33;

    localparam span_t SPAN_TAB [NUM_SPANS] = '{
        '{21'h00000, 21'h0001F, COLW_ZERO}, '{21'h0007F, 21'h0009F, COLW_ZERO},
        '{21'h00300, 21'h0036F, COLW_ZERO}, '{21'h00610, 21'h0061A, COLW_ZERO},
        '{21'h0064B, 21'h0065F, COLW_ZERO}, '{21'h01DC0, 21'h01DFF, COLW_ZERO},
        '{21'h020D0, 21'h020FF, COLW_ZERO}, '{21'h0FE20, 21'h0FE2F, COLW_ZERO},
        '{21'h0200B, 21'h0200D, COLW_ZERO}, '{21'h02060, 21'h02060, COLW_ZERO},
        '{21'h0FEFF, 21'h0FEFF, COLW_ZERO},
        '{21'h01100, 21'h0115F, COLW_WIDE}, '{21'h02329, 21'h0232A, COLW_WIDE},
        '{21'h02E80, 21'h0303E, COLW_WIDE}, '{21'h03040, 21'h033FF, COLW_WIDE},
        '{21'h03400, 21'h04DBF, COLW_WIDE}, '{21'h04E00, 21'h0A4CF, COLW_WIDE},
        '{21'h0A960, 21'h0A97F, COLW_WIDE}, '{21'h0AC00, 21'h0D7FF, COLW_WIDE},
        '{21'h0F900, 21'h0FAFF, COLW_WIDE}, '{21'h0FE10, 21'h0FE1F, COLW_WIDE},
        '{21'h0FE30, 21'h0FE6F, COLW_WIDE}, '{21'h0FF00, 21'h0FF60, COLW_WIDE},
        '{21'h0FFE0, 21'h0FFE6, COLW_WIDE},
        '{21'h1B000, 21'h1B0FF, COLW_WIDE}, '{21'h1B100, 21'h1B12F, COLW_WIDE},
        '{21'h20000, 21'h2A6DF, COLW_WIDE}, '{21'h2A700, 21'h2CEAF, COLW_WIDE},
        '{21'h2CEB0, 21'h2EBEF, COLW_WIDE}, '{21'h2F800, 21'h2FA1F, COLW_WIDE},
        '{21'h30000, 21'h3134F, COLW_WIDE}, '{21'h1F300, 21'h1F9FF, COLW_WIDE},
        '{21'h1FA00, 21'h1FAFF, COLW_WIDE}
    };

    // column width lookup, first matching range wins
    function automatic colw_t col_width(input cp_t cp);
        colw_t w;
        w = COLW_NARROW;
        for (int i = NUM_SPANS - 1; i >= 0; i--)
        begin
            if (cp >= SPAN_TAB[i].lo && cp <= SPAN_TAB[i].hi)
            begin
                w = SPAN_TAB[i].w;
            end
        end
        return w;
    endfunction

endpackage

@@ hdl/u8cw_in_if.sv @@
interface u8cw_in_if;
    import u8cw_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_string;

    modport source (output valid, output byte_in, output end_of_string, input ready);
    modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

@@ hdl/u8cw_out_if.sv @@
interface u8cw_out_if;
    import u8cw_pkg::*;

    logic        valid;
    logic        ready;
    cp_t         code_point;
    colw_t       char_width;
    logic        replaced;
    logic        run_last;
    logic        string_done;
    logic [15:0] total_width;

    modport source (
        output valid, output code_point, output char_width, output replaced,
        output run_last, output string_done, output total_width, input ready
    );
    modport sink (
        input valid, input code_point, input char_width, input replaced,
        input run_last, input string_done, input total_width, output ready
    );
endinterface

@@ hdl/utf8_decoder_with_column_width.sv @@
// channel  dir  payload                                              per transfer
// in_ch    in   byte_in[7:0], end_of_string                          one raw byte
// out_ch   out  code_point[20:0], char_width[1:0], replaced,         one code point
//               run_last, string_done, total_width[15:0]
//
// A byte sits in the input register and its results leave through the output
// register, one per cycle unless the output stalls; the byte leaves with its
// last result, or at once if it has none. A byte that closes a broken sequence
// gives up to four results and holds the input side until the last is loaded.
// Reset clears the open sequence and the running width. A stalled output register
// holds both the result and, once the input register is busy, the input side.
module utf8_decoder_with_column_width #(
    parameter int TOTAL_WIDTH_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    u8cw_in_if.sink       in_ch,
    u8cw_out_if.source    out_ch
);
    import u8cw_pkg::*;

    localparam int SW = TOTAL_WIDTH_BITS;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // decoder state
    cp_t        acc_reg;
    logic [2:0] pend_len_reg;
    logic [1:0] cont_cnt_reg;
    logic [SW-1:0] width_sum_reg;
    logic [1:0] idx_reg;

    // output register
    logic        out_vld_reg;
    cp_t         out_cp_reg;
    colw_t       out_w_reg;
    logic        out_repl_reg;
    logic        out_last_reg;
    logic        out_done_reg;
    logic [15:0] out_total_reg;

    // decode results for the byte in the input register
    logic       is_cont;
    cp_t        acc_shift;
    logic [1:0] cc_inc;
    logic       seq_full;
    logic       fin_bad;
    logic       do_lead;
    logic [2:0] n_repl;
    logic       has_tail;
    cp_t        tail_cp;
    logic       tail_bad;
    cp_t        acc_next;
    logic [2:0] pend_len_next;
    logic [1:0] cont_cnt_next;
    logic [2:0] n_res;

    // result selection
    logic          out_load;
    logic          emit;
    logic          idx_last;
    logic          done_item;
    logic          repl_slot;
    cp_t           res_cp;
    logic          res_bad;
    colw_t         res_w;
    logic          res_done;
    logic [SW:0]   sum_wide;
    logic [SW-1:0] sum_sat;
    logic [63:0]   sum_ext;

    // sequence decode
    always_comb
    begin
        is_cont   = (in_byte_reg & CONT_MASK) == CONT_CODE;
        acc_shift = {acc_reg[14:0], in_byte_reg[5:0]};
        cc_inc    = cont_cnt_reg + 2'd1;
        seq_full  = ({1'b0, cc_inc} + 3'd1) >= pend_len_reg;
        fin_bad   = (pend_len_reg == SEQ_LEN2 && acc_shift < MIN_CP2) ||
                    (pend_len_reg == SEQ_LEN3 && acc_shift < MIN_CP3) ||
                    (pend_len_reg == SEQ_LEN4 && acc_shift < MIN_CP4) ||
                    (acc_shift >= SURR_LO && acc_shift <= SURR_HI) ||
                    (acc_shift > CP_MAX);

        n_repl        = 3'd0;
        has_tail      = 1'b0;
        tail_cp       = REPL_CP;
        tail_bad      = 1'b1;
        acc_next      = acc_reg;
        pend_len_next = pend_len_reg;
        cont_cnt_next = cont_cnt_reg;
        do_lead       = 1'b0;

        if (pend_len_reg != SEQ_NONE && is_cont)
        begin
            if (seq_full)
            begin
                // sequence complete
                has_tail      = 1'b1;
                tail_bad      = fin_bad;
                tail_cp       = fin_bad ? REPL_CP : acc_shift;
                acc_next      = '0;
                pend_len_next = SEQ_NONE;
                cont_cnt_next = 2'd0;
            end
            else if (in_last_reg)
            begin
                // cut short by end of string, current byte counted
                n_repl        = {1'b0, cc_inc} + 3'd1;
                acc_next      = '0;
                pend_len_next = SEQ_NONE;
                cont_cnt_next = 2'd0;
            end
            else
            begin
                acc_next      = acc_shift;
                cont_cnt_next = cc_inc;
            end
        end
        else if (pend_len_reg != SEQ_NONE)
        begin
            // bad continuation: flush, then the byte starts anew
            n_repl        = {1'b0, cont_cnt_reg} + 3'd1;
            acc_next      = '0;
            pend_len_next = SEQ_NONE;
            cont_cnt_next = 2'd0;
            do_lead       = 1'b1;
        end
        else
        begin
            do_lead = 1'b1;
        end

        // lead byte
        if (do_lead)
        begin
            if (!in_byte_reg[7])
            begin
                has_tail = 1'b1;
                tail_cp  = {13'd0, in_byte_reg};
                tail_bad = 1'b0;
            end
            else if (in_byte_reg < LEAD2_LO || in_byte_reg >= LEAD_BAD)
            begin
                has_tail = 1'b1;
            end
            else if (in_last_reg)
            begin
                has_tail = 1'b1;
            end
            else
            begin
                cont_cnt_next = 2'd0;
                if (in_byte_reg < LEAD3_LO)
                begin
                    acc_next      = {16'd0, in_byte_reg[4:0]};
                    pend_len_next = SEQ_LEN2;
                end
                else if (in_byte_reg < LEAD4_LO)
                begin
                    acc_next      = {17'd0, in_byte_reg[3:0]};
                    pend_len_next = SEQ_LEN3;
                end
                else
                begin
                    acc_next      = {18'd0, in_byte_reg[2:0]};
                    pend_len_next = SEQ_LEN4;
                end
            end
        end

        n_res = n_repl + {2'd0, has_tail};
    end

    // pick the result at the current index and update the running width
    always_comb
    begin
        out_load  = !out_vld_reg || out_ch.ready;
        emit      = in_vld_reg && (n_res != 3'd0) && out_load;
        idx_last  = ({1'b0, idx_reg} == (n_res - 3'd1));
        done_item = in_vld_reg && ((n_res == 3'd0) || (emit && idx_last));
        repl_slot = {1'b0, idx_reg} < n_repl;
        res_cp    = repl_slot ? REPL_CP : tail_cp;
        res_bad   = repl_slot ? 1'b1 : tail_bad;
        res_w     = repl_slot ? COLW_NARROW : col_width(tail_cp);
        res_done  = idx_last && in_last_reg;
        sum_wide  = {1'b0, width_sum_reg} + (SW + 1)'(res_w);
        sum_sat   = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
        sum_ext   = 64'(sum_sat);
    end

    assign in_ch.ready = !in_vld_reg || done_item;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            acc_reg       <= '0;
            pend_len_reg  <= SEQ_NONE;
            cont_cnt_reg  <= 2'd0;
            width_sum_reg <= '0;
            idx_reg       <= 2'd0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (done_item)
            begin
                in_vld_reg <= 1'b0;
            end

            if (done_item)
            begin
                acc_reg      <= acc_next;
                pend_len_reg <= pend_len_next;
                cont_cnt_reg <= cont_cnt_next;
                idx_reg      <= 2'd0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (emit)
            begin
                width_sum_reg <= res_done ? '0 : sum_sat;
            end

            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.byte_in;
            in_last_reg <= in_ch.end_of_string;
        end
        if (emit)
        begin
            out_cp_reg    <= res_cp;
            out_w_reg     <= res_w;
            out_repl_reg  <= res_bad;
            out_last_reg  <= idx_last;
            out_done_reg  <= res_done;
            out_total_reg <= sum_ext[15:0];
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.code_point  = out_cp_reg;
    assign out_ch.char_width  = out_w_reg;
    assign out_ch.replaced    = out_repl_reg;
    assign out_ch.run_last    = out_last_reg;
    assign out_ch.string_done = out_done_reg;
    assign out_ch.total_width = out_total_reg;

    // running width is back at zero after the final result of a string
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res_done |=> width_sum_reg == '0)
        else $error("width sum not cleared after end of string");

    // result index stays inside the result count of the held byte
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && (n_res != 3'd0) |-> ({1'b0, idx_reg} < n_res))
        else $error("result index past result count");

    // end of string only on the last result of a byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_done_reg |-> out_last_reg)
        else $error("string done without run last");

    // replacement results carry the replacement code point
    a_repl_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_repl_reg |-> out_cp_reg == REPL_CP)
        else $error("replaced result with wrong code point");

    // pending length is none or a real sequence length
    a_pend_len: assert property (@(posedge clk) disable iff (!rst_n)
        pend_len_reg == SEQ_NONE || pend_len_reg == SEQ_LEN2 ||
        pend_len_reg == SEQ_LEN3 || pend_len_reg == SEQ_LEN4)
        else $error("bad pending sequence length");

endmodule

@@ verif/utf8_decoder_with_column_width_test.sv @@
module utf8_decoder_with_column_width_test;
    import u8cw_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 20;
    localparam logic [16:0] WIDTH_SUM_MAX = 17'h0FFFF;

    // one raw byte and its end flag
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } byte_item_t;

    // one decoded code point as it should leave the block
    typedef struct packed {
        cp_t         cp;
        colw_t       w;
        logic        repl;
        logic        run_last;
        logic        done;
        logic [15:0] total;
    } cp_result_t;

    logic clk = 1'b0;
    logic rst_n;

    u8cw_in_if  in_ch();
    u8cw_out_if out_ch();

    utf8_decoder_with_column_width DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // bytes waiting for the driver, code points waiting for the block
    byte_item_t byte_queue [$];
    cp_result_t expected_cps [$];
    cp_result_t byte_results [$];
    logic [7:0] string_bytes [$];
    byte_item_t next_item;

    // decoder state mirrored in the testbench
    cp_t         seq_acc = '0;
    logic [2:0]  seq_len = SEQ_NONE;
    logic [1:0]  seq_cnt = '0;
    logic [16:0] col_sum = '0;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // code points on both sides of every width range boundary
    cp_t span_marks [$] = '{
        21'h0001F, 21'h00020, 21'h0007E, 21'h0007F, 21'h0009F, 21'h000A0,
        21'h002FF, 21'h00300, 21'h0036F, 21'h00370, 21'h0060F, 21'h00610,
        21'h0061A, 21'h0061B, 21'h0064A, 21'h0064B, 21'h0065F, 21'h00660,
        21'h010FF, 21'h01100, 21'h0115F, 21'h01160, 21'h01DBF, 21'h01DC0,
        21'h01DFF, 21'h01E00, 21'h0200A, 21'h0200B, 21'h0200D, 21'h0200E,
        21'h0205F, 21'h02060, 21'h02061, 21'h020CF, 21'h020D0, 21'h020FF,
        21'h02100, 21'h02328, 21'h02329, 21'h0232A, 21'h0232B, 21'h02E7F,
        21'h02E80, 21'h0303E, 21'h0303F, 21'h03040, 21'h033FF, 21'h03400,
        21'h04DBF, 21'h04DC0, 21'h04DFF, 21'h04E00, 21'h0A4CF, 21'h0A4D0,
        21'h0A95F, 21'h0A960, 21'h0A97F, 21'h0A980, 21'h0ABFF, 21'h0AC00,
        21'h0D7FF, 21'h0E000, 21'h0F8FF, 21'h0F900, 21'h0FAFF, 21'h0FB00,
        21'h0FE0F, 21'h0FE10, 21'h0FE1F, 21'h0FE20, 21'h0FE2F, 21'h0FE30,
        21'h0FE6F, 21'h0FE70, 21'h0FEFE, 21'h0FEFF, 21'h0FF00, 21'h0FF60,
        21'h0FF61, 21'h0FFDF, 21'h0FFE0, 21'h0FFE6, 21'h0FFE7, 21'h0FFFD,
        21'h0FFFF, 21'h10000, 21'h1AFFF, 21'h1B000, 21'h1B0FF, 21'h1B100,
        21'h1B12F, 21'h1B130, 21'h1F2FF, 21'h1F300, 21'h1F9FF, 21'h1FA00,
        21'h1FAFF, 21'h1FB00, 21'h1FFFF, 21'h20000, 21'h2A6DF, 21'h2A6E0,
        21'h2A6FF, 21'h2A700, 21'h2CEAF, 21'h2CEB0, 21'h2EBEF, 21'h2EBF0,
        21'h2F7FF, 21'h2F800, 21'h2FA1F, 21'h2FA20, 21'h2FFFF, 21'h30000,
        21'h3134F, 21'h31350, 21'h10FFFF
    };

    // short directed strings, end flag in bit 8
    logic [8:0] directed_bytes [$] = '{
        9'h000,                                  // nul decodes as a character
        9'h0C3, 9'h0A9,                          // two byte sequence
        9'h0F0, 9'h09F, 9'h098, 9'h080,          // four byte wide emoji
        9'h080,                                  // stray continuation byte
        9'h0FF,                                  // invalid lead byte
        9'h0C0, 9'h080,                          // overlong encoding
        9'h0ED, 9'h0A0, 9'h080,                  // surrogate
        9'h0F4, 9'h090, 9'h080, 9'h080,          // above the code space
        9'h0F0, 9'h09F, 9'h098, 9'h141,          // bad continuation, four results
        9'h0E2, 9'h182,                          // sequence cut by end of string
        9'h1F0                                   // multi-byte lead with end flag
    };

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // terminal column width of a code point
    function automatic colw_t width_of(input cp_t cp);
        colw_t w;
        w = COLW_NARROW;
        if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F) ||
            (cp >= 21'h300 && cp <= 21'h36F) || (cp >= 21'h610 && cp <= 21'h61A) ||
            (cp >= 21'h64B && cp <= 21'h65F) || (cp >= 21'h1DC0 && cp <= 21'h1DFF) ||
            (cp >= 21'h20D0 && cp <= 21'h20FF) || (cp >= 21'hFE20 && cp <= 21'hFE2F) ||
            (cp >= 21'h200B && cp <= 21'h200D) || cp == 21'h2060 || cp == 21'hFEFF)
            w = COLW_ZERO;
        else if ((cp >= 21'h1100 && cp <= 21'h115F) || (cp >= 21'h2329 && cp <= 21'h232A) ||
            (cp >= 21'h2E80 && cp <= 21'h303E) || (cp >= 21'h3040 && cp <= 21'h4DBF) ||
            (cp >= 21'h4E00 && cp <= 21'hA4CF) || (cp >= 21'hA960 && cp <= 21'hA97F) ||
            (cp >= 21'hAC00 && cp <= 21'hD7FF) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
            (cp >= 21'hFE10 && cp <= 21'hFE1F) || (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
            (cp >= 21'hFF00 && cp <= 21'hFF60) || (cp >= 21'hFFE0 && cp <= 21'hFFE6) ||
            (cp >= 21'h1B000 && cp <= 21'h1B12F) || (cp >= 21'h20000 && cp <= 21'h2A6DF) ||
            (cp >= 21'h2A700 && cp <= 21'h2EBEF) || (cp >= 21'h2F800 && cp <= 21'h2FA1F) ||
            (cp >= 21'h30000 && cp <= 21'h3134F) || (cp >= 21'h1F300 && cp <= 21'h1FAFF))
            w = COLW_WIDE;
        return w;
    endfunction

    // add one code point to the results of the current byte
    task automatic push_cp(input cp_t cp, input logic bad);
        cp_result_t r;
        colw_t w;
        if (byte_results.size() < 4)
        begin
            w = width_of(cp);
            if (col_sum + w > WIDTH_SUM_MAX)
                col_sum = WIDTH_SUM_MAX;
            else
                col_sum = col_sum + w;
            r.cp = cp;
            r.w = w;
            r.repl = bad;
            r.run_last = 1'b0;
            r.done = 1'b0;
            r.total = col_sum[15:0];
            byte_results.push_back(r);
        end
    endtask

    // replace an open sequence: lead plus each stored continuation byte
    task automatic flush_seq();
        push_cp(REPL_CP, 1'b1);
        for (int k = 0; k < seq_cnt; k++)
            push_cp(REPL_CP, 1'b1);
        seq_len = SEQ_NONE;
        seq_cnt = '0;
        seq_acc = '0;
    endtask

    // byte seen with no sequence open
    task automatic open_seq(input logic [7:0] b, input logic eos);
        if (!b[7])
            push_cp({13'd0, b}, 1'b0);
        else if (b < LEAD2_LO || b >= LEAD_BAD)
            push_cp(REPL_CP, 1'b1);
        else
        begin
            if (b < LEAD3_LO)
            begin
                seq_acc = {16'd0, b[4:0]};
                seq_len = SEQ_LEN2;
            end
            else if (b < LEAD4_LO)
            begin
                seq_acc = {17'd0, b[3:0]};
                seq_len = SEQ_LEN3;
            end
            else
            begin
                seq_acc = {18'd0, b[2:0]};
                seq_len = SEQ_LEN4;
            end
            seq_cnt = '0;
            if (eos)
            begin
                push_cp(REPL_CP, 1'b1);
                seq_len = SEQ_NONE;
                seq_acc = '0;
            end
        end
    endtask

    // complete sequence: overlong, surrogate and out of range give one replacement
    task automatic close_seq();
        logic bad;
        bad = (seq_len == SEQ_LEN2 && seq_acc < MIN_CP2) ||
              (seq_len == SEQ_LEN3 && seq_acc < MIN_CP3) ||
              (seq_len == SEQ_LEN4 && seq_acc < MIN_CP4) ||
              (seq_acc >= SURR_LO && seq_acc <= SURR_HI) || seq_acc > CP_MAX;
        push_cp(bad ? REPL_CP : seq_acc, bad);
        seq_len = SEQ_NONE;
        seq_cnt = '0;
        seq_acc = '0;
    endtask

    // expected code points for one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        cp_result_t r;
        if (seq_len != SEQ_NONE)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                seq_acc = {seq_acc[14:0], b[5:0]};
                seq_cnt = seq_cnt + 2'd1;
                if ({1'b0, seq_cnt} + 3'd1 >= seq_len)
                    close_seq();
                else if (eos)
                    flush_seq();
            end
            else
            begin
                flush_seq();
                open_seq(b, eos);
            end
        end
        else
            open_seq(b, eos);
        if (byte_results.size() != 0)
        begin
            r = byte_results[$];
            r.run_last = 1'b1;
            if (eos)
            begin
                r.done = 1'b1;
                col_sum = '0;
            end
            byte_results[$] = r;
        end
        while (byte_results.size() != 0)
            expected_cps.push_back(byte_results.pop_front());
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // compare one output transfer with the oldest expected code point
    task automatic check_result();
        cp_result_t want;
        string diffs;
        if (expected_cps.size() == 0)
            report_mismatch($sformatf("code point %h with nothing expected", out_ch.code_point));
        else
        begin
            want = expected_cps.pop_front();
            diffs = "";
            if (out_ch.code_point !== want.cp)
                diffs = {diffs, $sformatf(" code_point %h/%h", out_ch.code_point, want.cp)};
            if (out_ch.char_width !== want.w)
                diffs = {diffs, $sformatf(" char_width %0d/%0d", out_ch.char_width, want.w)};
            if (out_ch.replaced !== want.repl)
                diffs = {diffs, $sformatf(" replaced %b/%b", out_ch.replaced, want.repl)};
            if (out_ch.run_last !== want.run_last)
                diffs = {diffs, $sformatf(" run_last %b/%b", out_ch.run_last, want.run_last)};
            if (out_ch.string_done !== want.done)
                diffs = {diffs, $sformatf(" string_done %b/%b", out_ch.string_done, want.done)};
            if (out_ch.total_width !== want.total)
                diffs = {diffs, $sformatf(" total_width %0d/%0d", out_ch.total_width,
                                          want.total)};
            if (diffs != "")
                report_mismatch({"got/expected", diffs});
        end
    endtask

    // utf-8 encoding of a code point at a chosen length, first keep bytes only
    task automatic encode_cp(input cp_t cp, input int len, input int keep);
        logic [7:0] enc [4];
        enc[0] = {1'b0, cp[6:0]};
        enc[1] = {2'b10, cp[5:0]};
        enc[2] = {2'b10, cp[5:0]};
        enc[3] = {2'b10, cp[5:0]};
        case (len)
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
            end
            4:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < keep; i++)
            string_bytes.push_back(enc[i]);
    endtask

    function automatic int natural_len(input cp_t cp);
        if (cp < 21'h80)
            return 1;
        else if (cp < 21'h800)
            return 2;
        else if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    // one character of random text, mostly well formed
    task automatic add_random_char();
        int kind;
        int len;
        cp_t cp;
        kind = $urandom_range(99);
        if (kind < 25)
            encode_cp(cp_t'($urandom_range(21'h7F)), 1, 1);
        else if (kind < 37)
            encode_cp(cp_t'($urandom_range(21'h7FF, 21'h80)), 2, 2);
        else if (kind < 55)
        begin
            cp = span_marks[$urandom_range(span_marks.size() - 1)];
            len = natural_len(cp);
            encode_cp(cp, len, len);
        end
        else if (kind < 67)
        begin
            cp = cp_t'($urandom_range(21'hFFFF, 21'h800));
            if (cp >= SURR_LO && cp <= SURR_HI)
                cp = cp ^ 21'h4000;
            encode_cp(cp, 3, 3);
        end
        else if (kind < 77)
            encode_cp(cp_t'($urandom_range(21'h10FFFF, 21'h10000)), 4, 4);
        else if (kind < 81)
        begin
            // overlong form of a shorter code point
            len = $urandom_range(4, 2);
            cp = cp_t'($urandom_range(len == 2 ? 21'h7F : (len == 3 ? 21'h7FF : 21'hFFFF)));
            encode_cp(cp, len, len);
        end
        else if (kind < 84)
            encode_cp(cp_t'($urandom_range(SURR_HI, SURR_LO)), 3, 3);
        else if (kind < 87)
            encode_cp(cp_t'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
        else if (kind < 94)
        begin
            // sequence cut short
            len = $urandom_range(4, 2);
            cp = cp_t'($urandom_range(
                     len == 2 ? 21'h7FF : (len == 3 ? 21'hFFFF : 21'h10FFFF),
                     len == 2 ? 21'h80 : (len == 3 ? 21'h800 : 21'h10000)));
            encode_cp(cp, len, $urandom_range(len - 1, 1));
        end
        else
            string_bytes.push_back(8'($urandom_range(8'hFF)));
    endtask

    // random strings until about nbytes are queued
    task automatic load_strings(input int nbytes);
        int added;
        byte_item_t item;
        added = 0;
        while (added < nbytes)
        begin
            string_bytes.delete();
            repeat ($urandom_range(10, 1))
                add_random_char();
            for (int i = 0; i < string_bytes.size(); i++)
            begin
                item.data = string_bytes[i];
                item.eos = (i == string_bytes.size() - 1);
                byte_queue.push_back(item);
            end
            added += string_bytes.size();
        end
    endtask

    // wait until every byte is taken and every code point has come out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_ch.valid || expected_cps.size() != 0);
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.byte_in <= 8'h00;
            in_ch.end_of_string <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_item = byte_queue.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.byte_in <= next_item.data;
                in_ch.end_of_string <= next_item.eos;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result receiver, with random stalls and long holds on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.byte_in, in_ch.end_of_string);
            if (out_ch.valid && out_ch.ready)
                check_result();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL utf8_decoder_with_column_width");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset and stimulus phases
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender rarely idle, receiver mostly stalled
        send_gap_pct = 8;
        recv_stall_pct = 66;
        foreach (directed_bytes[i])
            byte_queue.push_back('{data: directed_bytes[i][7:0], eos: directed_bytes[i][8]});
        wait_drained();

        // long receiver hold while the sender keeps offering
        load_strings(120);
        hold_reqs = hold_reqs + 1;
        wait_drained();

        // sender mostly idle, receiver rarely stalled
        send_gap_pct = 66;
        recv_stall_pct = 8;
        load_strings(115);
        wait_drained();

        // no idling on either side
        send_gap_pct = 0;
        recv_stall_pct = 0;
        load_strings(115);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS utf8_decoder_with_column_width");
        else
            $display("FAIL utf8_decoder_with_column_width");
        $finish;
    end

endmodule

@@ utf8_decoder_with_column_width.f @@
hdl/u8cw_pkg.sv
hdl/u8cw_in_if.sv
hdl/u8cw_out_if.sv
hdl/utf8_decoder_with_column_width.sv
verif/utf8_decoder_with_column_width_test.sv
